@@ design/kwmf_pkg.sv @@
`timescale 1ns / 1ps

package kwmf_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MATCH_THRESHOLD = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WORD_LENGTH     = 1'd1;

  localparam int unsigned CFG_DATA_W = 8;
  localparam int unsigned THR_W      = 8;
  localparam int unsigned WL_W       = 4;
  localparam int unsigned BASE_W     = 2;

  localparam logic [THR_W-1:0] THR_RESET = 8'd2;
  localparam logic [WL_W-1:0]  WL_RESET  = 4'd10;

  // mode codes
  localparam logic MODE_REF   = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  typedef enum logic [2:0] {
    ST_INIT_CLEAR,
    ST_IDLE,
    ST_CLEAR,
    ST_LOOKUP,
    ST_EVAL
  } kwmf_state_e;

  typedef struct packed {
    logic accept;    // take the offered beat, advance the rolling word
    logic clr_step;  // zero one map row, advance the clear pointer
    logic rd;        // read the map row of the current word
    logic eval;      // set the bit or count the hit, load a result
  } kwmf_cmd_t;

  typedef struct packed {
    logic start_clear;  // offered beat is the first reference base
    logic clr_last;     // clear pointer sits on the last row
    logic need_out;     // current item is the last query base
    logic out_blocked;  // result register full and not taken this cycle
  } kwmf_status_t;

endpackage

@@ design/kwmf_ctrl.sv @@
`timescale 1ns / 1ps

module kwmf_ctrl (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  input  kwmf_pkg::kwmf_status_t status_i,
  output logic                  in_ready_o,
  output kwmf_pkg::kwmf_cmd_t   cmd_o
);

  kwmf_pkg::kwmf_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= kwmf_pkg::ST_INIT_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d    = state_q;
    in_ready_o = 1'b0;
    cmd_o      = '0;
    case (state_q)
      kwmf_pkg::ST_INIT_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) state_d = kwmf_pkg::ST_IDLE;
      end
      kwmf_pkg::ST_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = status_i.start_clear ? kwmf_pkg::ST_CLEAR : kwmf_pkg::ST_LOOKUP;
        end
      end
      kwmf_pkg::ST_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (status_i.clr_last) state_d = kwmf_pkg::ST_LOOKUP;
      end
      kwmf_pkg::ST_LOOKUP: begin
        cmd_o.rd = 1'b1;
        state_d  = kwmf_pkg::ST_EVAL;
      end
      kwmf_pkg::ST_EVAL: begin
        // hold while a result must go out and the output register is full and not taken
        if (!(status_i.need_out && status_i.out_blocked)) begin
          cmd_o.eval = 1'b1;
          state_d    = kwmf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = kwmf_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

@@ design/kwmf_datapath.sv @@
`timescale 1ns / 1ps

module kwmf_datapath #(
  parameter int unsigned MAX_WORD_LENGTH = 10
) (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [kwmf_pkg::CFG_IDX_W-1:0]         cfg_idx_i,
  input  logic [kwmf_pkg::CFG_DATA_W-1:0]        cfg_data_i,
  input  logic                                   in_mode_i,
  input  logic [kwmf_pkg::BASE_W-1:0]            in_base_i,
  input  logic                                   in_first_i,
  input  logic                                   in_last_i,
  input  logic                                   out_ready_i,
  input  kwmf_pkg::kwmf_cmd_t                    cmd_i,
  output kwmf_pkg::kwmf_status_t                 status_o,
  output logic                                   out_valid_o,
  output logic                                   out_similar_o,
  output logic [kwmf_pkg::THR_W-1:0]             out_count_o
);

  localparam int unsigned WORD_W = 2 * MAX_WORD_LENGTH;
  localparam int unsigned COL_W  = (WORD_W >= 8) ? 6 : WORD_W - 1;
  localparam int unsigned ROW_W  = WORD_W - COL_W;
  localparam int unsigned COL_N  = 1 << COL_W;
  localparam int unsigned ROWS   = 1 << ROW_W;

  // configuration
  logic [kwmf_pkg::THR_W-1:0] thr_q;
  logic [kwmf_pkg::WL_W-1:0]  wl_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= kwmf_pkg::THR_RESET;
      wl_q  <= kwmf_pkg::WL_RESET;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        kwmf_pkg::CFG_MATCH_THRESHOLD: thr_q <= cfg_data_i[kwmf_pkg::THR_W-1:0];
        kwmf_pkg::CFG_WORD_LENGTH:     wl_q  <= cfg_data_i[kwmf_pkg::WL_W-1:0];
        default: ;
      endcase
    end
  end

  logic [kwmf_pkg::WL_W-1:0] eff_len;
  always_comb begin
    if (wl_q == '0) begin
      eff_len = kwmf_pkg::WL_W'(1);
    end else if (wl_q > kwmf_pkg::WL_W'(MAX_WORD_LENGTH)) begin
      eff_len = kwmf_pkg::WL_W'(MAX_WORD_LENGTH);
    end else begin
      eff_len = wl_q;
    end
  end

  // rolling word and base count
  logic [WORD_W-1:0]         roll_q, roll_d, roll_base, word_mask;
  logic [kwmf_pkg::WL_W-1:0] seen_q, seen_d, seen_base;
  logic [kwmf_pkg::THR_W-1:0] matches_q, matches_d;
  logic [WORD_W-1:0]         idx_q;
  logic                      formed_q, mode_q, last_q;
  logic                      hit;

  assign roll_base = in_first_i ? '0 : roll_q;
  assign roll_d    = (roll_base << 2) | WORD_W'(in_base_i);
  assign seen_base = in_first_i ? '0 : seen_q;
  assign seen_d    = (seen_base < eff_len) ? seen_base + 1'b1 : eff_len;
  assign word_mask = ~({WORD_W{1'b1}} << {eff_len, 1'b0});

  always_comb begin
    matches_d = matches_q;
    if (cmd_i.accept && in_first_i) begin
      matches_d = '0;
    end else if (cmd_i.eval && mode_q == kwmf_pkg::MODE_QUERY && formed_q
                 && matches_q < thr_q && hit) begin
      matches_d = matches_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      roll_q    <= '0;
      seen_q    <= '0;
      matches_q <= '0;
    end else begin
      matches_q <= matches_d;
      if (cmd_i.accept) begin
        roll_q <= roll_d;
        seen_q <= seen_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      idx_q    <= roll_d & word_mask;
      formed_q <= (seen_d == eff_len);
      mode_q   <= in_mode_i;
      last_q   <= in_last_i;
    end
  end

  // presence map, one row read or written per cycle
  logic [COL_N-1:0] map_mem [ROWS];
  logic [COL_N-1:0] rdata_q, wdata;
  logic [ROW_W-1:0] clr_ptr_q, mem_addr;
  logic [COL_W-1:0] col;
  logic             mem_we;

  assign col      = idx_q[COL_W-1:0];
  assign hit      = rdata_q[col];
  assign mem_addr = cmd_i.clr_step ? clr_ptr_q : idx_q[WORD_W-1:COL_W];
  assign mem_we   = cmd_i.clr_step
                  | (cmd_i.eval & (mode_q == kwmf_pkg::MODE_REF) & formed_q);
  assign wdata    = cmd_i.clr_step ? '0 : (rdata_q | (COL_N'(1) << col));

  always_ff @(posedge clk_i) begin
    if (mem_we) map_mem[mem_addr] <= wdata;
    if (cmd_i.rd) rdata_q <= map_mem[mem_addr];
  end

  // wraps back to zero at the end of every sweep
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_ptr_q <= '0;
    end else if (cmd_i.clr_step) begin
      clr_ptr_q <= clr_ptr_q + 1'b1;
    end
  end

  // result register
  logic                      out_valid_q, load_out;
  logic                      similar_q;
  logic [kwmf_pkg::THR_W-1:0] count_q;

  assign load_out = cmd_i.eval & (mode_q == kwmf_pkg::MODE_QUERY) & last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      similar_q <= (matches_d >= thr_q);
      count_q   <= matches_d;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign out_similar_o = similar_q;
  assign out_count_o   = count_q;

  assign status_o.start_clear = in_first_i & (in_mode_i == kwmf_pkg::MODE_REF);
  assign status_o.clr_last    = (clr_ptr_q == '1);
  assign status_o.need_out    = (mode_q == kwmf_pkg::MODE_QUERY) & last_q;
  assign status_o.out_blocked = out_valid_q & ~out_ready_i;

endmodule

@@ design/kmer_word_match_filter_top.sv @@
`timescale 1ns / 1ps
// Steps: accept the base, read its map row, evaluate; evaluating the last query base loads
//   the output register, and waits while that register is full and not taken.
// The next base waits until the last is evaluated (read-then-write of the single map port);
//   a first reference base adds a clear sweep of 2^(2*MAX_WORD_LENGTH-6) map rows (16384).
// Reset: asynchronous, active low; afterwards the same clear sweep runs with tready low.
module kmer_word_match_filter_top #(
  parameter int unsigned MAX_WORD_LENGTH = 10  // 1 to 12 bases
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [kwmf_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [kwmf_pkg::CFG_DATA_W-1:0]     cfg_data_i,
  // base stream in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [1:0] base, [2] first, [7:3] zero
  input  logic        s_axis_tlast,
  input  logic        s_axis_tuser,   // [0] mode
  // result stream out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata    // [0] similar, [8:1] match_count, [15:9] zero
);

  kwmf_pkg::kwmf_cmd_t    cmd;
  kwmf_pkg::kwmf_status_t status;
  logic                   similar;
  logic [kwmf_pkg::THR_W-1:0] count;

  // sequencer: init clear, idle, clear, lookup, evaluate
  kwmf_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .status_i   (status),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd)
  );

  // registers, rolling word, presence map, match counter, result register
  kwmf_datapath #(
    .MAX_WORD_LENGTH (MAX_WORD_LENGTH)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .in_mode_i     (s_axis_tuser),
    .in_base_i     (s_axis_tdata[1:0]),
    .in_first_i    (s_axis_tdata[2]),
    .in_last_i     (s_axis_tlast),
    .out_ready_i   (m_axis_tready),
    .cmd_i         (cmd),
    .status_o      (status),
    .out_valid_o   (m_axis_tvalid),
    .out_similar_o (similar),
    .out_count_o   (count)
  );

  assign m_axis_tdata = {7'd0, count, similar};

endmodule

@@ design/kwmf_checker.sv @@
`timescale 1ns / 1ps

module kwmf_checker (
  input logic                            clk_i,
  input logic                            rst_ni,
  input logic                            cfg_we_i,
  input logic [kwmf_pkg::CFG_IDX_W-1:0]  cfg_idx_i,
  input logic [kwmf_pkg::CFG_DATA_W-1:0] cfg_data_i,
  input logic                            s_axis_tvalid,
  input logic                            s_axis_tready,
  input logic                            m_axis_tvalid,
  input logic                            m_axis_tready,
  input logic [15:0]                     m_axis_tdata
);

  // track the threshold as written on the port
  logic [kwmf_pkg::THR_W-1:0] thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= kwmf_pkg::THR_RESET;
    end else if (cfg_we_i && cfg_idx_i == kwmf_pkg::CFG_MATCH_THRESHOLD) begin
      thr_q <= cfg_data_i[kwmf_pkg::THR_W-1:0];
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat dropped or changed while stalled");

  a_similar: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[0] == (m_axis_tdata[8:1] >= thr_q))
    else $error("similar flag disagrees with count and threshold");

  a_pad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> m_axis_tdata[15:9] == 7'd0)
    else $error("result padding bits not zero");

  a_busy_after_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("base taken while previous base still in work");

endmodule

bind kmer_word_match_filter_top kwmf_checker u_kwmf_checker (.*);

@@ tb/tb_top.sv @@
`timescale 1ns / 1ps

// Base-stream testbench for the k-mer word match filter.
// Each accepted base runs through a local model of the presence map and the
// rolling word; every query report that comes out is matched against the
// oldest pending prediction.
module tb_top;

  localparam int unsigned MAX_WL = 10;
  localparam int unsigned WORD_W = 2 * MAX_WL;

  // one report of a finished query, as it leaves on the result stream
  typedef struct packed {
    logic                       similar;
    logic [kwmf_pkg::THR_W-1:0] count;
  } match_report_t;

  logic                            clk_i;
  logic                            rst_ni;
  logic                            cfg_we_i;
  logic [kwmf_pkg::CFG_IDX_W-1:0]  cfg_idx_i;
  logic [kwmf_pkg::CFG_DATA_W-1:0] cfg_data_i;
  logic                            s_axis_tvalid;
  logic                            s_axis_tready;
  logic [7:0]                      s_axis_tdata;   // [1:0] base, [2] first, [7:3] zero
  logic                            s_axis_tlast;
  logic                            s_axis_tuser;   // [0] mode
  logic                            m_axis_tvalid;
  logic                            m_axis_tready;
  logic [15:0]                     m_axis_tdata;   // [0] similar, [8:1] match_count, [15:9] zero

  // local copy of the block state and its registers
  bit                         map_words[int unsigned];
  logic [WORD_W-1:0]          roll_word;
  int unsigned                bases_in_word;
  logic [kwmf_pkg::THR_W-1:0] word_hits;
  logic [kwmf_pkg::THR_W-1:0] cur_threshold;
  logic [kwmf_pkg::WL_W-1:0]  cur_word_len;

  match_report_t         expected_reports[$];

  // traffic shaping: idle shares in percent of cycles, and a receiver hold length
  int unsigned           tx_idle_pct;
  int unsigned           rx_idle_pct;
  int unsigned           rx_hold_cycles;

  int unsigned           n_bases;
  int unsigned           n_reports;
  int unsigned           n_map_clears;
  int unsigned           n_mismatch;

  kmer_word_match_filter_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_idx_i     (cfg_idx_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tlast  (s_axis_tlast),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Advance the local model by one base. Returns 1 when the base closes a
  // query, with the report that the block must send for it.
  function automatic bit predict_match(input logic mode, input logic [1:0] base,
                                       input logic first, input logic last,
                                       output match_report_t rpt);
    int unsigned       span;
    logic [WORD_W:0]   mask;
    logic [WORD_W-1:0] key;
    // out-of-range lengths clamp to 1 and to the built maximum
    span = cur_word_len;
    if (span < 1) span = 1;
    if (span > MAX_WL) span = MAX_WL;
    if (first) begin
      roll_word     = '0;
      bases_in_word = 0;
      word_hits     = '0;
      if (mode == kwmf_pkg::MODE_REF) begin
        map_words.delete();
        n_map_clears++;
      end
    end
    roll_word = {roll_word[WORD_W-3:0], base};
    if (bases_in_word < span) bases_in_word++;
    // a length lowered mid-sequence pulls the count down at once
    if (bases_in_word > span) bases_in_word = span;
    if (bases_in_word == span) begin
      mask = ({{WORD_W{1'b0}}, 1'b1} << (2 * span)) - 1'b1;
      key  = roll_word & mask[WORD_W-1:0];
      if (mode == kwmf_pkg::MODE_REF) begin
        map_words[key] = 1'b1;
      end else if (word_hits < cur_threshold && map_words.exists(key)) begin
        word_hits++;
      end
    end
    rpt.similar = (word_hits >= cur_threshold);
    rpt.count   = word_hits;
    return (mode == kwmf_pkg::MODE_QUERY) && last;
  endfunction

  task automatic report_mismatch(input string what);
    $display("MISMATCH at %0t ns: %s", $time, what);
    n_mismatch++;
  endtask

  // Offer one base, hold it until the block takes it, then predict.
  task automatic send_base(input logic mode, input logic [1:0] base,
                           input logic first, input logic last);
    match_report_t rpt;
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = {5'b0, first, base};
    s_axis_tlast  = last;
    s_axis_tuser  = mode;
    do @(posedge clk_i); while (!s_axis_tready);
    if (predict_match(mode, base, first, last, rpt)) expected_reports.push_back(rpt);
    n_bases++;
  endtask

  // Drop valid, wait for every pending report and for the block to go idle.
  task automatic settle();
    @(negedge clk_i);
    s_axis_tvalid = 1'b0;
    while (expected_reports.size() != 0 || !s_axis_tready) @(posedge clk_i);
    repeat (12) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [kwmf_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kwmf_pkg::CFG_DATA_W-1:0] val);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = val;
    @(negedge clk_i);
    cfg_we_i = 1'b0;
    if (idx == kwmf_pkg::CFG_MATCH_THRESHOLD) cur_threshold = val;
    else cur_word_len = val[kwmf_pkg::WL_W-1:0];
  endtask

  // Queries against the cleared map after reset: a one-base query with
  // first and last together, and a query shorter than a word.
  task automatic test_empty_map();
    send_base(kwmf_pkg::MODE_QUERY, 2'd2, 1'b1, 1'b1);
    send_base(kwmf_pkg::MODE_QUERY, 2'd3, 1'b1, 1'b0);
    send_base(kwmf_pkg::MODE_QUERY, 2'd1, 1'b0, 1'b0);
    send_base(kwmf_pkg::MODE_QUERY, 2'd0, 1'b0, 1'b1);
    settle();
  endtask

  // Shortest word and highest threshold; the last reference base reports nothing.
  task automatic test_short_word_high_threshold();
    write_reg(kwmf_pkg::CFG_MATCH_THRESHOLD, 8'd255);
    write_reg(kwmf_pkg::CFG_WORD_LENGTH, 8'd1);
    send_base(kwmf_pkg::MODE_REF, 2'd0, 1'b1, 1'b0);
    send_base(kwmf_pkg::MODE_REF, 2'd3, 1'b0, 1'b1);
    send_base(kwmf_pkg::MODE_QUERY, 2'd0, 1'b1, 1'b0);
    send_base(kwmf_pkg::MODE_QUERY, 2'd1, 1'b0, 1'b0);
    send_base(kwmf_pkg::MODE_QUERY, 2'd2, 1'b0, 1'b0);
    send_base(kwmf_pkg::MODE_QUERY, 2'd3, 1'b0, 1'b1);
    settle();
  endtask

  // Zero threshold counts nothing and calls the query similar; length 0 acts as 1.
  task automatic test_threshold_zero();
    write_reg(kwmf_pkg::CFG_MATCH_THRESHOLD, 8'd0);
    write_reg(kwmf_pkg::CFG_WORD_LENGTH, 8'd0);
    send_base(kwmf_pkg::MODE_QUERY, 2'd0, 1'b1, 1'b0);
    send_base(kwmf_pkg::MODE_QUERY, 2'd0, 1'b0, 1'b1);
    settle();
  endtask

  // Start a query with an over-range length, shorten the word mid-query.
  task automatic test_length_change_mid_query();
    write_reg(kwmf_pkg::CFG_MATCH_THRESHOLD, 8'd1);
    write_reg(kwmf_pkg::CFG_WORD_LENGTH, 8'd15);
    send_base(kwmf_pkg::MODE_QUERY, 2'd0, 1'b1, 1'b0);
    send_base(kwmf_pkg::MODE_QUERY, 2'd0, 1'b0, 1'b0);
    send_base(kwmf_pkg::MODE_QUERY, 2'd0, 1'b0, 1'b0);
    settle();
    write_reg(kwmf_pkg::CFG_WORD_LENGTH, 8'd2);
    send_base(kwmf_pkg::MODE_QUERY, 2'd3, 1'b0, 1'b1);
    settle();
  endtask

  // Swap between reference and query bases with no restart in between.
  task automatic test_mode_switch();
    write_reg(kwmf_pkg::CFG_MATCH_THRESHOLD, 8'd3);
    write_reg(kwmf_pkg::CFG_WORD_LENGTH, 8'd2);
    send_base(kwmf_pkg::MODE_REF, 2'd1, 1'b1, 1'b0);
    send_base(kwmf_pkg::MODE_REF, 2'd2, 1'b0, 1'b0);
    send_base(kwmf_pkg::MODE_REF, 2'd1, 1'b0, 1'b0);
    send_base(kwmf_pkg::MODE_QUERY, 2'd2, 1'b0, 1'b0);
    send_base(kwmf_pkg::MODE_REF, 2'd0, 1'b0, 1'b0);
    send_base(kwmf_pkg::MODE_QUERY, 2'd1, 1'b0, 1'b1);
    settle();
  endtask

  // Hold the result side for a long stretch while one-base queries keep
  // coming, so the output register fills and the input stalls.
  task automatic test_result_backpressure();
    int k;
    tx_idle_pct = 0;
    write_reg(kwmf_pkg::CFG_MATCH_THRESHOLD, 8'd1);
    write_reg(kwmf_pkg::CFG_WORD_LENGTH, 8'd1);
    @(posedge clk_i);
    rx_hold_cycles = 300;
    for (k = 0; k < 24; k++) send_base(kwmf_pkg::MODE_QUERY, k[1:0], 1'b1, 1'b1);
    settle();
  endtask

  // Rounds of one reference followed by queries drawn from it with some
  // mutation, mixed with rounds of unstructured bases. New settings per round.
  task automatic test_random_traffic(input int unsigned tx_pct, input int unsigned rx_pct,
                                     input int unsigned n_items);
    int unsigned stop_at;
    int unsigned ref_len;
    int unsigned q_len;
    int unsigned start;
    int unsigned k;
    logic [1:0]  b;
    logic [1:0]  ref_bases[$];
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    stop_at = n_bases + n_items;
    while (n_bases < stop_at) begin
      case ($urandom_range(0, 9))
        0:       write_reg(kwmf_pkg::CFG_MATCH_THRESHOLD, 8'd0);
        1:       write_reg(kwmf_pkg::CFG_MATCH_THRESHOLD, 8'd255);
        2:       write_reg(kwmf_pkg::CFG_MATCH_THRESHOLD, 8'($urandom_range(0, 255)));
        default: write_reg(kwmf_pkg::CFG_MATCH_THRESHOLD, 8'($urandom_range(1, 6)));
      endcase
      case ($urandom_range(0, 9))
        0:       write_reg(kwmf_pkg::CFG_WORD_LENGTH, 8'($urandom_range(11, 15)));
        1:       write_reg(kwmf_pkg::CFG_WORD_LENGTH, 8'd0);
        default: write_reg(kwmf_pkg::CFG_WORD_LENGTH, 8'($urandom_range(1, 10)));
      endcase
      if ($urandom_range(0, 99) < 85) begin
        ref_len = $urandom_range(1, 40);
        ref_bases.delete();
        for (k = 0; k < ref_len; k++) begin
          b = 2'($urandom_range(0, 3));
          ref_bases.push_back(b);
          send_base(kwmf_pkg::MODE_REF, b, k == 0, k == ref_len - 1);
        end
        repeat ($urandom_range(2, 8)) begin
          q_len = $urandom_range(1, 30);
          start = $urandom_range(0, ref_len - 1);
          for (k = 0; k < q_len; k++) begin
            // mostly copy the reference so long words still hit
            if ($urandom_range(0, 99) < 80) b = ref_bases[(start + k) % ref_len];
            else b = 2'($urandom_range(0, 3));
            send_base(kwmf_pkg::MODE_QUERY, b, k == 0, k == q_len - 1);
          end
        end
      end else begin
        // keep reference restarts rare here: each one costs a full map clear
        repeat ($urandom_range(5, 25))
          send_base(1'($urandom_range(0, 1)), 2'($urandom_range(0, 3)),
                    $urandom_range(0, 19) == 0, $urandom_range(0, 3) == 0);
      end
      settle();
    end
  endtask

  // Receiver: a long hold when asked, otherwise random stalls.
  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (rx_hold_cycles > 0) begin
        m_axis_tready = 1'b0;
        rx_hold_cycles--;
      end else begin
        m_axis_tready = ($urandom_range(0, 99) >= rx_idle_pct);
      end
    end
  end

  // Compare every report that leaves the block with the oldest prediction.
  initial begin
    match_report_t got;
    match_report_t want;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        got.similar = m_axis_tdata[0];
        got.count   = m_axis_tdata[8:1];
        n_reports++;
        if (expected_reports.size() == 0) begin
          report_mismatch($sformatf("unexpected report similar=%0d count=%0d",
                                    got.similar, got.count));
        end else begin
          want = expected_reports.pop_front();
          if (got.similar !== want.similar)
            report_mismatch($sformatf("similar %0d, expected %0d",
                                      got.similar, want.similar));
          if (got.count !== want.count)
            report_mismatch($sformatf("match_count %0d, expected %0d",
                                      got.count, want.count));
        end
      end
    end
  end

  initial begin
    #12_000_000;
    $display("kmer_word_match_filter_top test failed");
    $finish;
  end

  initial begin
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_idx_i      = '0;
    cfg_data_i     = '0;
    s_axis_tvalid  = 1'b0;
    s_axis_tdata   = '0;
    s_axis_tlast   = 1'b0;
    s_axis_tuser   = 1'b0;
    tx_idle_pct    = 19;
    rx_idle_pct    = 85;
    rx_hold_cycles = 0;
    n_bases        = 0;
    n_reports      = 0;
    n_map_clears   = 0;
    n_mismatch     = 0;
    roll_word      = '0;
    bases_in_word  = 0;
    word_hits      = '0;
    cur_threshold  = kwmf_pkg::THR_RESET;
    cur_word_len   = kwmf_pkg::WL_RESET;
    map_words.delete();

    // hold reset, then release it; the block then clears its map on its own
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_empty_map();
    test_short_word_high_threshold();
    test_threshold_zero();
    test_length_change_mid_query();
    test_mode_switch();
    test_result_backpressure();
    test_random_traffic(19, 85, 380);
    test_random_traffic(85, 19, 380);
    test_random_traffic(0, 0, 380);
    settle();

    $display("Sent %0d bases over %0d map clears and checked %0d query reports,",
             n_bases, n_map_clears, n_reports);
    $display("across thresholds 0 to 255 and word lengths 0 to 15 under random stalls.");
    if (n_mismatch == 0) begin
      $display("kmer_word_match_filter_top test passed");
    end else begin
      $display("kmer_word_match_filter_top test failed");
    end
    $finish;
  end

endmodule

@@ kmer_word_match_filter_top.f @@
design/kwmf_pkg.sv
design/kwmf_ctrl.sv
design/kwmf_datapath.sv
design/kmer_word_match_filter_top.sv
design/kwmf_checker.sv
tb/tb_top.sv
